@@ design/knnpd_pkg.sv @@
// Shared widths and constants for the k-nearest-neighbour point density block.
// No dependencies; imported by knnpd_sqrt, knnpd_div and knn_point_density_top.
package knnpd_pkg;

  localparam int COORD_W = 16;
  localparam int POINT_W = 3 * COORD_W;
  localparam int DIST_W  = 35;
  localparam int ROOT_W  = 26;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int DEN_W   = 61;
  localparam int NUM_W   = 43;
  localparam int GK_W    = 37;
  localparam int PFULL_W = 67;
  localparam int DENS_W  = 32;
  localparam int K_W     = 5;
  localparam int GAIN_W  = 32;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [DIST_W-1:0] DIST_ONES = '1;
  localparam logic [29:0]       INV_Q32   = 30'd1025347913;
  localparam logic [DENS_W-1:0] DENS_MAX  = '1;

  localparam logic REG_K    = 1'b0;
  localparam logic REG_GAIN = 1'b1;

endpackage

@@ design/knnpd_sqrt.sv @@
// Iterative integer square root of d2 * 2^16, two radicand bits per cycle.
// Depends on knnpd_pkg.
module knnpd_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [knnpd_pkg::DIST_W-1:0]  d2,
  output logic                          done,
  output logic [knnpd_pkg::ROOT_W-1:0]  root
);
  import knnpd_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W);

  state_t              state_r;
  logic [RAD_W-1:0]    rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                done_r;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                fits;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial  = REM_W'({root_r, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (go) begin
            rad_r   <= RAD_W'({d2, 16'b0});
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          rad_r  <= rad_r << 2;
          rem_r  <= fits ? rem_sh - trial : rem_sh;
          root_r <= {root_r[ROOT_W-2:0], fits};
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(ROOT_W - 1)) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ design/knnpd_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on knnpd_pkg.
module knnpd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [knnpd_pkg::NUM_W-1:0]  dividend,
  input  logic [knnpd_pkg::DEN_W-1:0]  divisor,
  output logic                         done,
  output logic [knnpd_pkg::NUM_W-1:0]  quot
);
  import knnpd_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  localparam int REM_W = DEN_W + 1;
  localparam int CNT_W = $clog2(NUM_W);

  state_t            state_r;
  logic [NUM_W-1:0]  dvd_r;
  logic [DEN_W-1:0]  dvs_r;
  logic [REM_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic [REM_W-1:0]  rem_sh;
  logic              fits;

  assign rem_sh = {rem_r[REM_W-2:0], dvd_r[NUM_W-1]};
  assign fits   = rem_sh >= REM_W'(dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (go) begin
            dvd_r   <= dividend;
            dvs_r   <= divisor;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          rem_r <= fits ? rem_sh - REM_W'(dvs_r) : rem_sh;
          dvd_r <= {dvd_r[NUM_W-2:0], fits};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(NUM_W - 1)) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

@@ design/knn_point_density_top.sv @@
// k-nearest-neighbour point density: point store, scan sequencer, shared multiplier.
// Depends on knnpd_pkg, knnpd_sqrt and knnpd_div.
// A non-final point is stored and the block stays idle. A final point starts a run that, per
// stored point, scans the store (one store read per cycle), then takes a square root and a
// divide (neither on a zero radius); busy stays high. One result strobe per point.
// Synchronous active-low reset clears the point count and sets k=10, gain=1.0.
module knn_point_density_top #(
  parameter int MAX_POINTS     = 64,
  parameter int MAX_NEIGHBOURS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [knnpd_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [knnpd_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [knnpd_pkg::COORD_W-1:0] in_coord_z,
  input  logic                                in_final_point,
  output logic                                out_valid,
  output logic [knnpd_pkg::DENS_W-1:0]        out_density,
  output logic                                out_saturated,
  output logic                                out_last_density,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [knnpd_pkg::ADDR_W-1:0]        paddr,
  input  logic [knnpd_pkg::DATA_W-1:0]        pwdata,
  output logic [knnpd_pkg::DATA_W-1:0]        prdata,
  output logic                                pready
);
  import knnpd_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int LW = $clog2(MAX_NEIGHBOURS);
  localparam int KW = $clog2(MAX_NEIGHBOURS + 1);
  localparam int KX = (KW > K_W) ? KW : K_W;
  localparam int RX = (KW > CW) ? KW : CW;

  typedef enum logic [3:0] {
    S_IDLE, S_NUM0, S_NUM1, S_NUM2, S_PT, S_PTW, S_SCAN, S_SEL,
    S_CHK, S_SQRT, S_DEN0, S_DEN1, S_DIVS, S_DIV, S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [K_W-1:0]      k_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       i_r;
  logic [CW-1:0]       j_r;
  logic [KW-1:0]       kc_r;
  logic [LW-1:0]       rank_idx_r;
  logic [GK_W-1:0]     gk_r;
  logic [63:0]         plo_r;
  logic [NUM_W-1:0]    num_r;
  logic [POINT_W-1:0]  cur_r;
  logic [POINT_W-1:0]  rdata_r;
  logic                rv_r;
  logic                dv_r;
  logic [DIST_W-1:0]   d_r;
  logic [DIST_W-1:0]   d2_r;
  logic [DIST_W-1:0]   near_r [MAX_NEIGHBOURS];
  logic [DIST_W-1:0]   near_nxt [MAX_NEIGHBOURS];
  logic [ROOT_W-1:0]   root_r;
  logic [63:0]         dlo_r;
  logic [DEN_W-1:0]    den_r;
  logic                out_valid_r;
  logic [DENS_W-1:0]   out_density_r;
  logic                out_sat_r;
  logic                out_last_r;
  logic [POINT_W-1:0]  mem [MAX_POINTS];
  logic [AW-1:0]       raddr;

  logic                accept;
  logic                room;
  logic                last_pt;
  logic [KX-1:0]       k_x;
  logic [KW-1:0]       kc;
  logic [RX-1:0]       rank;
  logic [31:0]         mul_a, mul_b;
  logic [63:0]         mul_p;
  logic [PFULL_W-1:0]  p_full;
  logic signed [COORD_W:0] dx, dy, dz;
  logic signed [2*COORD_W+1:0] sx, sy, sz;
  logic [DIST_W-1:0]   dsum;
  logic                sqrt_go, sqrt_done, div_go, div_done;
  logic [ROOT_W-1:0]   sqrt_root;
  logic [NUM_W-1:0]    div_quot;

  assign accept  = start && !busy;
  assign room    = count_r < CW'(MAX_POINTS);
  assign last_pt = (i_r + 1'b1) == count_r;
  assign busy    = state_r != S_IDLE;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_GAIN) ? gain_r : DATA_W'(k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= K_W'(10);
      gain_r <= GAIN_W'(65536);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_K) k_r <= pwdata[K_W-1:0];
      else gain_r <= pwdata;
    end
  end

  always_comb begin
    k_x = KX'(k_r);
    if (k_x < KX'(2)) kc = KW'(2);
    else if (k_x > KX'(MAX_NEIGHBOURS)) kc = KW'(MAX_NEIGHBOURS);
    else kc = KW'(k_x);
    rank = (RX'(kc_r) < RX'(count_r)) ? RX'(kc_r) : RX'(count_r);
  end

  always_comb begin
    raddr = (state_r == S_PT) ? i_r[AW-1:0] : j_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[count_r[AW-1:0]] <= {in_coord_z, in_coord_y, in_coord_x};
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    dx   = $signed({cur_r[COORD_W-1], cur_r[COORD_W-1:0]})
         - $signed({rdata_r[COORD_W-1], rdata_r[COORD_W-1:0]});
    dy   = $signed({cur_r[2*COORD_W-1], cur_r[2*COORD_W-1:COORD_W]})
         - $signed({rdata_r[2*COORD_W-1], rdata_r[2*COORD_W-1:COORD_W]});
    dz   = $signed({cur_r[3*COORD_W-1], cur_r[3*COORD_W-1:2*COORD_W]})
         - $signed({rdata_r[3*COORD_W-1], rdata_r[3*COORD_W-1:2*COORD_W]});
    sx   = dx * dx;
    sy   = dy * dy;
    sz   = dz * dz;
    dsum = DIST_W'(sx[31:0]) + DIST_W'(sy[31:0]) + DIST_W'(sz[31:0]);
  end

  always_comb begin
    for (int s = 0; s < MAX_NEIGHBOURS; s++) begin
      if (d_r < near_r[s]) begin
        if (s > 0 && d_r < near_r[(s > 0) ? s - 1 : 0]) near_nxt[s] = near_r[(s > 0) ? s - 1 : 0];
        else near_nxt[s] = d_r;
      end else begin
        near_nxt[s] = near_r[s];
      end
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_NUM0: begin
        mul_a = gain_r;
        mul_b = 32'(kc_r);
      end
      S_NUM1: begin
        mul_a = 32'(gk_r[18:0]);
        mul_b = 32'(INV_Q32);
      end
      S_NUM2: begin
        mul_a = 32'(gk_r[GK_W-1:19]);
        mul_b = 32'(INV_Q32);
      end
      S_DEN0: begin
        mul_a = 32'(d2_r[17:0]);
        mul_b = 32'(root_r);
      end
      S_DEN1: begin
        mul_a = 32'(d2_r[DIST_W-1:18]);
        mul_b = 32'(root_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p  = mul_a * mul_b;
    p_full = (PFULL_W'(mul_p) << 19) + PFULL_W'(plo_r);
  end

  assign sqrt_go = (state_r == S_CHK) && (d2_r != '0);
  assign div_go  = state_r == S_DIVS;

  knnpd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (sqrt_go),
    .d2    (d2_r),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  knnpd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (num_r),
    .divisor  (den_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept && in_final_point) state_nxt = S_NUM0;
      S_NUM0: state_nxt = S_NUM1;
      S_NUM1: state_nxt = S_NUM2;
      S_NUM2: state_nxt = S_PT;
      S_PT:   state_nxt = S_PTW;
      S_PTW:  state_nxt = S_SCAN;
      S_SCAN: if (j_r == count_r && !rv_r && !dv_r) state_nxt = S_SEL;
      S_SEL:  state_nxt = S_CHK;
      S_CHK:  state_nxt = (d2_r == '0) ? S_EMIT : S_SQRT;
      S_SQRT: if (sqrt_done) state_nxt = S_DEN0;
      S_DEN0: state_nxt = S_DEN1;
      S_DEN1: state_nxt = S_DIVS;
      S_DIVS: state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_EMIT;
      S_EMIT: state_nxt = last_pt ? S_IDLE : S_PT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rv_r        <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (room) count_r <= count_r + 1'b1;
            kc_r <= kc;
          end
        end
        S_NUM0: begin
          gk_r       <= GK_W'(mul_p);
          rank_idx_r <= LW'(rank - 1'b1);
          i_r        <= '0;
        end
        S_NUM1: plo_r <= mul_p;
        S_NUM2: num_r <= p_full[PFULL_W-1:PFULL_W-NUM_W];
        S_PTW: begin
          cur_r <= rdata_r;
          j_r   <= '0;
          rv_r  <= 1'b0;
          dv_r  <= 1'b0;
          for (int s = 0; s < MAX_NEIGHBOURS; s++) near_r[s] <= DIST_ONES;
        end
        S_SCAN: begin
          if (j_r != count_r) begin
            j_r  <= j_r + 1'b1;
            rv_r <= 1'b1;
          end else begin
            rv_r <= 1'b0;
          end
          dv_r <= rv_r;
          d_r  <= dsum;
          if (dv_r) begin
            for (int s = 0; s < MAX_NEIGHBOURS; s++) near_r[s] <= near_nxt[s];
          end
        end
        S_SEL: d2_r <= near_r[rank_idx_r];
        S_CHK: begin
          if (d2_r == '0) begin
            out_valid_r   <= 1'b1;
            out_density_r <= DENS_MAX;
            out_sat_r     <= 1'b1;
            out_last_r    <= last_pt;
          end
        end
        S_SQRT: if (sqrt_done) root_r <= sqrt_root;
        S_DEN0: dlo_r <= mul_p;
        S_DEN1: den_r <= (DEN_W'(mul_p) << 18) + DEN_W'(dlo_r);
        S_DIV: begin
          if (div_done) begin
            out_valid_r <= 1'b1;
            out_last_r  <= last_pt;
            if (div_quot[NUM_W-1:DENS_W] != '0) begin
              out_density_r <= DENS_MAX;
              out_sat_r     <= 1'b1;
            end else begin
              out_density_r <= div_quot[DENS_W-1:0];
              out_sat_r     <= 1'b0;
            end
          end
        end
        S_EMIT: begin
          if (last_pt) count_r <= '0;
          else i_r <= i_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_density      = out_density_r;
  assign out_saturated    = out_sat_r;
  assign out_last_density = out_last_r;

endmodule

@@ design/knnpd_checker.sv @@
// Port-level checks for knn_point_density_top, attached by bind.
// Depends on knn_point_density_top.
module knnpd_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_final_point,
  input logic out_valid,
  input logic out_last_density
);

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result transfer outside a run");

  a_results_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result transfers");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_density |=> !busy)
    else $error("busy after last result");

  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_final_point |=> !busy)
    else $error("busy after non-final point");

endmodule

bind knn_point_density_top knnpd_checker u_knnpd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_final_point   (in_final_point),
  .out_valid        (out_valid),
  .out_last_density (out_last_density)
);
